FILE: rtl/core/gbfs_pkg.sv
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared types and constants for the grid breadth-first path planner.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  localparam int GridRows  = 10;
  localparam int GridCols  = 10;
  localparam int Cells     = GridRows * GridCols;
  localparam int CellW     = $clog2(Cells);
  localparam int CoordW    = 4;
  localparam int MaxOut    = 32;
  localparam int CntW      = $clog2(MaxOut);

  typedef logic [CellW-1:0]  cell_t;
  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    logic  clr_start;  // clear visited bits, seed queue with start
    logic  pop;        // pop queue head into current cell
    logic  try_nb;     // examine neighbour nb_dir of current cell
    logic  tr_start;   // begin trace from target
    logic  tr_step;    // follow one predecessor link
    logic  em_start;   // begin emission from top of path stack
    logic  em_step;    // consume one path entry
    logic [1:0] nb_dir;
  } gbfs_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic q_empty;
    logic found;
    logic tr_done;
    logic em_done;
    logic em_out;      // current step yields a waypoint
  } gbfs_sts_t;

  function automatic logic blocked(coord_t r, coord_t c, logic [2:0] sel);
    logic b;
    b = (r >= 4'd3) && (r <= 4'd6) && (c >= 4'd3) && (c <= 4'd6);
    case (sel)
      3'd1: b = b | (r == 4'd8 && c == 4'd1);
      3'd2: b = b | (r == 4'd8 && c == 4'd4);
      3'd3: b = b | (r == 4'd8 && c == 4'd8);
      3'd4: b = b | (r == 4'd5 && c == 4'd8);
      3'd5: b = b | (r == 4'd1 && c == 4'd8);
      3'd6: b = b | (r == 4'd1 && c == 4'd5);
      default: b = b;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/gbfs_datapath.sv
// ----------------------------------------------------------------------------
// gbfs_datapath
// Visited bits, predecessor store, queue, path stack and waypoint logic.
// ----------------------------------------------------------------------------
module gbfs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  gbfs_pkg::gbfs_cmd_t cmd,
  output gbfs_pkg::gbfs_sts_t sts,
  input  gbfs_pkg::coord_t    sx,
  input  gbfs_pkg::coord_t    sy,
  input  gbfs_pkg::coord_t    gx,
  input  gbfs_pkg::coord_t    gy,
  input  logic [2:0]          sel,
  output gbfs_pkg::coord_t    wx,
  output gbfs_pkg::coord_t    wy
);
  import gbfs_pkg::*;

  // cell kept as row/col pair; CellW bits index memories as row*Cols+col
  logic [Cells-1:0] visited;
  logic [2*CoordW-1:0] pred [Cells];
  logic [2*CoordW-1:0] queue [Cells];
  logic [2*CoordW-1:0] path [Cells];
  logic [CellW:0] qhead, qtail, plen;
  coord_t cr, cc, tr, tc;
  logic [2:0] prev;
  logic found;
  logic [CntW-1:0] nout;

  function automatic cell_t idx(coord_t r, coord_t c);
    return cell_t'(r * GridCols + c);
  endfunction

  // neighbour of current cell
  coord_t nr, nc;
  logic   nb_ok;
  always_comb begin
    nr = cr;
    nc = cc;
    nb_ok = 1'b1;
    case (cmd.nb_dir)
      2'd0: begin nc = cc + 4'd1; nb_ok = (cc != coord_t'(GridCols-1)); end
      2'd1: begin nc = cc - 4'd1; nb_ok = (cc != '0); end
      2'd2: begin nr = cr + 4'd1; nb_ok = (cr != coord_t'(GridRows-1)); end
      default: begin nr = cr - 4'd1; nb_ok = (cr != '0); end
    endcase
  end
  logic is_goal;
  assign is_goal = (nr == gx) && (nc == gy);

  logic take;
  assign take = nb_ok && !visited[idx(nr, nc)] && (is_goal || !blocked(nr, nc, sel));

  // emission: top entry a = path[plen-1], next b = path[plen-2]
  logic [2*CoordW-1:0] pa, pb;
  logic [2:0] dir;
  always_ff @(posedge clk) begin
    pa <= path[plen[CellW-1:0] - CellW'(1)];
    pb <= path[plen[CellW-1:0] - CellW'(2)];
  end
  always_comb begin
    if (pb[CoordW-1:0] == pa[CoordW-1:0])
      dir = (pb[2*CoordW-1:CoordW] > pa[2*CoordW-1:CoordW]) ? 3'd0 : 3'd1;
    else
      dir = (pb[CoordW-1:0] > pa[CoordW-1:0]) ? 3'd2 : 3'd3;
  end
  assign wx = pa[CoordW-1:0];
  assign wy = pa[2*CoordW-1:CoordW];

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      qhead <= '0;
      qtail <= '0;
      found <= 1'b0;
      plen <= '0;
      prev <= 3'd4;
      nout <= '0;
    end else begin
      if (cmd.clr_start) begin
        // only the start cell is left marked
        visited <= {{(Cells-1){1'b0}}, 1'b1} << idx(sx, sy);
        queue[0] <= {sy, sx};
        qhead <= '0;
        qtail <= (CellW+1)'(1);
        found <= 1'b0;
      end
      if (cmd.pop) begin
        cr <= queue[qhead[CellW-1:0]][CoordW-1:0];
        cc <= queue[qhead[CellW-1:0]][2*CoordW-1:CoordW];
        qhead <= qhead + 1'b1;
      end
      if (cmd.try_nb && take) begin
        visited[idx(nr, nc)] <= 1'b1;
        pred[idx(nr, nc)] <= {cc, cr};
        if (is_goal) found <= 1'b1;
        else if (qtail < (CellW+1)'(Cells)) begin
          queue[qtail[CellW-1:0]] <= {nc, nr};
          qtail <= qtail + 1'b1;
        end
      end
      if (cmd.tr_start) begin
        tr <= gx;
        tc <= gy;
        path[0] <= {gy, gx};
        plen <= (CellW+1)'(1);
      end
      if (cmd.tr_step) begin
        tr <= pred[idx(tr, tc)][CoordW-1:0];
        tc <= pred[idx(tr, tc)][2*CoordW-1:CoordW];
        path[plen[CellW-1:0]] <= pred[idx(tr, tc)];
        plen <= plen + 1'b1;
      end
      if (cmd.em_start) begin
        prev <= 3'd4;
        nout <= '0;
      end
      if (cmd.em_step) begin
        prev <= dir;
        plen <= plen - 1'b1;
        if (sts.em_out) nout <= nout + 1'b1;
      end
    end
  end

  assign sts.clr_done = 1'b1;
  assign sts.q_empty  = (qhead >= qtail);
  assign sts.found    = found;
  assign sts.tr_done  = (tr == sx) && (tc == sy);
  assign sts.em_done  = (plen < (CellW+1)'(2));
  assign sts.em_out   = (dir != prev) && (nout != CntW'(MaxOut-1));

endmodule

FILE: rtl/core/gbfs_ctrl.sv
// ----------------------------------------------------------------------------
// gbfs_ctrl
// Sequencer for search, trace-back and waypoint emission.
// ----------------------------------------------------------------------------
module gbfs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                trivial,
  input  logic                same,
  output logic                busy,
  input  gbfs_pkg::gbfs_sts_t sts,
  output gbfs_pkg::gbfs_cmd_t cmd,
  output logic                o_load,
  output logic                o_goal,
  output logic                o_reach,
  input  logic                o_free
);
  import gbfs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_CLR  = 9'b000000010, S_POP  = 9'b000000100,
    S_NB   = 9'b000001000, S_TRS  = 9'b000010000, S_TR   = 9'b000100000,
    S_EMS  = 9'b001000000, S_EM   = 9'b010000000, S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [1:0] nb, nb_next;
  logic reach, reach_next;
  logic rd_wait, rd_wait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nb <= '0;
      reach <= 1'b0;
      rd_wait <= 1'b0;
    end else begin
      state <= state_next;
      nb <= nb_next;
      reach <= reach_next;
      rd_wait <= rd_wait_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    nb_next = nb;
    reach_next = reach;
    rd_wait_next = 1'b0;
    cmd = '0;
    cmd.nb_dir = nb;
    o_load = 1'b0;
    o_goal = 1'b0;
    o_reach = reach;
    case (state)
      S_IDLE: if (in_fire) begin
        if (trivial) begin reach_next = same; state_next = S_FIN; end
        else state_next = S_CLR;
      end
      // request coordinates are registered by now
      S_CLR: begin cmd.clr_start = 1'b1; state_next = S_POP; end
      S_POP: begin
        if (sts.found) begin reach_next = 1'b1; state_next = S_TRS; end
        else if (sts.q_empty) begin reach_next = 1'b0; state_next = S_FIN; end
        else begin cmd.pop = 1'b1; nb_next = '0; state_next = S_NB; end
      end
      S_NB: begin
        cmd.try_nb = 1'b1;
        nb_next = nb + 2'd1;
        if (nb == 2'd3) state_next = S_POP;
        // found is registered; finishing the four tries is harmless since
        // the goal cell is now visited and further pushes are never read
      end
      S_TRS: begin cmd.tr_start = 1'b1; state_next = S_TR; end
      S_TR: begin
        if (sts.tr_done) state_next = S_EMS;
        else cmd.tr_step = 1'b1;
      end
      S_EMS: begin cmd.em_start = 1'b1; rd_wait_next = 1'b1; state_next = S_EM; end
      S_EM: begin
        if (!rd_wait) begin
          if (sts.em_done) state_next = S_FIN;
          else if (!sts.em_out) begin cmd.em_step = 1'b1; rd_wait_next = 1'b1; end
          else if (o_free) begin
            o_load = 1'b1;
            cmd.em_step = 1'b1;
            rd_wait_next = 1'b1;
          end
        end
      end
      S_FIN: if (o_free) begin o_load = 1'b1; o_goal = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/grid_bfs_path_planner.sv
// ----------------------------------------------------------------------------
// grid_bfs_path_planner
// Breadth-first shortest path on a 10x10 grid, emits start, turns and target.
// ----------------------------------------------------------------------------
//  channel  dir  fields (low bit up)
//  s_axis   in   tdata: start_x, start_y, goal_x, goal_y
//  m_axis   out  tdata: waypoint_x, waypoint_y, reachable; tlast: last
//  cfg      in   data: extra_obstacle
//
// One request at a time. Search pops each queued cell and tries its four
// neighbours, trace-back follows one predecessor link per path cell, and
// emission walks the path stack from the start towards the target.
// Reset clears all control state; the visited map is cleared on each searched request.
// A stalled output holds the sequencer until the item is taken.
module grid_bfs_path_planner (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // start_x, start_y, goal_x, goal_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // waypoint_x, waypoint_y, reachable, zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data        // extra_obstacle
);
  import gbfs_pkg::*;

  logic [2:0] sel;
  coord_t sx, sy, gx, gy, wx, wy;
  logic busy, in_fire, trivial, same, o_load, o_goal, o_reach, o_free;
  gbfs_cmd_t cmd;
  gbfs_sts_t sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) sel <= '0;
    else if (cfg_valid) sel <= cfg_data;
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sx <= s_axis_tdata[3:0];
      sy <= s_axis_tdata[7:4];
      gx <= s_axis_tdata[11:8];
      gy <= s_axis_tdata[15:12];
    end
  end

  logic [3:0] ix0, iy0, ix1, iy1;
  assign ix0 = s_axis_tdata[3:0];
  assign iy0 = s_axis_tdata[7:4];
  assign ix1 = s_axis_tdata[11:8];
  assign iy1 = s_axis_tdata[15:12];
  assign same = (ix0 == ix1) && (iy0 == iy1) && !(ix0 >= 4'(GridRows) ||
                iy0 >= 4'(GridCols) || ix1 >= 4'(GridRows) || iy1 >= 4'(GridCols));
  assign trivial = same || ix0 >= 4'(GridRows) || iy0 >= 4'(GridCols) ||
                   ix1 >= 4'(GridRows) || iy1 >= 4'(GridCols);

  gbfs_ctrl u_ctrl (
    .clk, .rst, .in_fire, .trivial, .same, .busy, .sts, .cmd,
    .o_load, .o_goal, .o_reach, .o_free
  );

  gbfs_datapath u_dp (
    .clk, .rst, .cmd, .sts, .sx, .sy, .gx, .gy, .sel, .wx, .wy
  );

  assign o_free = !m_axis_tvalid || m_axis_tready;
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (o_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (o_load) begin
      m_axis_tdata <= {7'd0, o_reach, o_goal ? gy : wy, o_goal ? gx : wx};
      m_axis_tlast <= o_goal;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("input taken while busy");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    o_load |-> o_free) else $error("output overwritten");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (o_load && o_goal) |=> !busy) else $error("not idle after last item");

endmodule
